FILE: design/bmsh_pkg.sv
// Shared types and constants for the button matrix scanner with sample history.
// Used by bmsh_lane, bmsh_merge and button_matrix_scan_history.
`default_nettype none

package bmsh_pkg;

	// Fixed field widths of the scan and result beats
	localparam int COL_W   = 3;
	localparam int ROW_W   = 8;
	localparam int IDX_W   = 7;
	localparam int IDX_X_W = IDX_W + 1;
	localparam int CNT_W   = 5;
	localparam int HIST_W  = 16;

	typedef enum logic [0:0] {
		OP_SCAN = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// What one row lane reports for a read beat (all zero when it holds no hit)
	typedef struct packed {
		logic              fresh;
		logic [CNT_W-1:0]  count;
		logic [HIST_W-1:0] history;
	} lane_result_t;

	// One result beat
	typedef struct packed {
		logic [COL_W-1:0]  column_scanned;
		logic              fresh_valid;
		logic [CNT_W-1:0]  sample_count;
		logic [HIST_W-1:0] history_bits;
	} out_beat_t;

endpackage

`default_nettype wire

FILE: design/button_matrix_scan_history.sv
// Button matrix scanner with per-input sample history (top level).
// Depends on bmsh_pkg, bmsh_lane and bmsh_merge.
//
// Usage:
//   Input channel (in_valid / in_stall) carries scan and read beats. A scan
//   beat brings the active-low row levels of the column held by the internal
//   column counter; every row lane shifts its pressed bit into that column's
//   history word and bumps its saturating sample count, then the counter
//   advances with wrap. A read beat names one input and returns its history
//   and count, and clears the count.
//   Output channel (out_valid / out_stall) returns exactly one beat per
//   input beat, in order.
//   An accepted beat is registered in the output register. Throughput: one
//   beat per cycle unless the output stalls; all row lanes update in the same cycle.
//   A stalled output holds in the output register; one further beat lands
//   in a skid register, after which in_stall rises until the output drains.
//   Reset clears every history word, every count and the column counter;
//   beats are accepted as soon as reset is released.
`default_nettype none

module button_matrix_scan_history #(
	parameter int COLUMNS       = 8,
	parameter int ROWS          = 8,
	parameter int INPUTS        = 64,
	parameter int MAX_COUNT     = 16,
	parameter int HISTORY_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          operation,
	input  wire logic [bmsh_pkg::ROW_W-1:0]    row_levels,
	input  wire logic [bmsh_pkg::IDX_W-1:0]    input_index,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [bmsh_pkg::COL_W-1:0]         column_scanned,
	output logic                               fresh_valid,
	output logic [bmsh_pkg::CNT_W-1:0]         sample_count,
	output logic [bmsh_pkg::HIST_W-1:0]        history_bits
);

	logic                          accept;
	logic                          take;
	bmsh_pkg::op_t                 op;
	logic [bmsh_pkg::COL_W-1:0]    col_q;
	logic [bmsh_pkg::COL_W:0]      col_inc;
	bmsh_pkg::lane_result_t        lane_res [ROWS];
	bmsh_pkg::out_beat_t           beat;
	logic                          main_valid_q;
	bmsh_pkg::out_beat_t           main_q;
	logic                          skid_valid_q;
	bmsh_pkg::out_beat_t           skid_q;

	assign op       = bmsh_pkg::op_t'(operation);
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign take     = main_valid_q && !out_stall;
	assign col_inc  = {1'b0, col_q} + (bmsh_pkg::COL_W + 1)'(1);

	// Advance the column counter on every scan beat, wrapping at the last column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (accept && (op == bmsh_pkg::OP_SCAN)) begin
			if (col_inc >= (bmsh_pkg::COL_W + 1)'(COLUMNS)) begin
				col_q <= '0;
			end else begin
				col_q <= col_inc[bmsh_pkg::COL_W-1:0];
			end
		end
	end

	// One lane per matrix row
	for (genvar l = 0; l < ROWS; l++) begin : g_lane
		bmsh_lane #(
			.COLUMNS       (COLUMNS),
			.ROWS          (ROWS),
			.INPUTS        (INPUTS),
			.MAX_COUNT     (MAX_COUNT),
			.HISTORY_WIDTH (HISTORY_WIDTH),
			.LANE          (l)
		) u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.beat_en     (accept),
			.operation   (op),
			.row_level   (row_levels[l]),
			.column      (col_q),
			.input_index (input_index),
			.result      (lane_res[l])
		);
	end

	bmsh_merge #(
		.ROWS (ROWS)
	) u_merge (
		.operation (op),
		.column    (col_q),
		.lanes     (lane_res),
		.beat      (beat)
	);

	// Output register plus skid stage: hold while stalled, drain skid first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (skid_valid_q) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= accept;
				end
			end else if (!main_valid_q) begin
				main_valid_q <= accept;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers carry no reset
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (accept) begin
				main_q <= beat;
			end
		end else if (!main_valid_q) begin
			if (accept) begin
				main_q <= beat;
			end
		end else if (accept) begin
			skid_q <= beat;
		end
	end

	assign out_valid      = main_valid_q;
	assign column_scanned = main_q.column_scanned;
	assign fresh_valid    = main_q.fresh_valid;
	assign sample_count   = main_q.sample_count;
	assign history_bits   = main_q.history_bits;

endmodule

`default_nettype wire

FILE: design/bmsh_lane.sv
// One row lane: history and sample count for the inputs of a single matrix row,
// one entry per column. Depends on bmsh_pkg.
`default_nettype none

module bmsh_lane #(
	parameter int COLUMNS       = 8,
	parameter int ROWS          = 8,
	parameter int INPUTS        = 64,
	parameter int MAX_COUNT     = 16,
	parameter int HISTORY_WIDTH = 16,
	parameter int LANE          = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       beat_en,
	input  wire bmsh_pkg::op_t              operation,
	input  wire logic                       row_level,
	input  wire logic [bmsh_pkg::COL_W-1:0] column,
	input  wire logic [bmsh_pkg::IDX_W-1:0] input_index,
	output bmsh_pkg::lane_result_t          result
);

	localparam int BASE = (ROWS - 1 - LANE) * COLUMNS;
	localparam int CIW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int CW   = $clog2(MAX_COUNT + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_COUNT);

	logic [HISTORY_WIDTH-1:0] hist_q [COLUMNS];
	logic [CW-1:0]            cnt_q  [COLUMNS];

	logic [bmsh_pkg::IDX_X_W-1:0] idx_x;
	logic [bmsh_pkg::IDX_X_W-1:0] offset;
	logic [CIW-1:0]               rd_sel;
	logic [CIW-1:0]               wr_sel;
	logic                         hit;
	logic                         scan;
	logic                         pressed;
	logic [CW-1:0]                cnt_rd;
	logic [HISTORY_WIDTH-1:0]     hist_rd;
	logic [CW+bmsh_pkg::CNT_W-1:0]             cnt_x;
	logic [HISTORY_WIDTH+bmsh_pkg::HIST_W-1:0] hist_x;

	// Decode which entry a read addresses and whether this lane owns it
	always_comb begin
		idx_x   = {1'b0, input_index};
		offset  = idx_x - bmsh_pkg::IDX_X_W'(BASE);
		rd_sel  = offset[CIW-1:0];
		wr_sel  = column[CIW-1:0];
		scan    = (operation == bmsh_pkg::OP_SCAN);
		pressed = ~row_level;
		hit     = (operation == bmsh_pkg::OP_READ)
			&& (idx_x >= bmsh_pkg::IDX_X_W'(BASE))
			&& (idx_x < bmsh_pkg::IDX_X_W'(BASE + COLUMNS))
			&& (idx_x < bmsh_pkg::IDX_X_W'(INPUTS));
	end

	// Per-entry storage; entries whose input number falls outside the store stay zero
	for (genvar c = 0; c < COLUMNS; c++) begin : g_entry
		if (BASE + c < INPUTS) begin : g_live
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					hist_q[c] <= '0;
					cnt_q[c]  <= '0;
				end else if (beat_en) begin
					if (scan && (wr_sel == CIW'(c))) begin
						hist_q[c] <= HISTORY_WIDTH'({hist_q[c], pressed});
						if (cnt_q[c] < MAX_CNT) begin
							cnt_q[c] <= cnt_q[c] + CW'(1);
						end else begin
							cnt_q[c] <= MAX_CNT;
						end
					end else if (hit && (rd_sel == CIW'(c))) begin
						cnt_q[c] <= '0;
					end
				end
			end
		end else begin : g_dead
			assign hist_q[c] = '0;
			assign cnt_q[c]  = '0;
		end
	end

	// Read the addressed entry and fit it to the result field widths
	always_comb begin
		cnt_rd  = cnt_q[rd_sel];
		hist_rd = hist_q[rd_sel];
		cnt_x   = {{bmsh_pkg::CNT_W{1'b0}}, cnt_rd};
		hist_x  = {{bmsh_pkg::HIST_W{1'b0}}, hist_rd};
		result  = '0;
		if (hit) begin
			result.fresh   = (cnt_rd != '0);
			result.count   = cnt_x[bmsh_pkg::CNT_W-1:0];
			result.history = hist_x[bmsh_pkg::HIST_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: design/bmsh_merge.sv
// Merge stage: combines the row lane reports into one result beat.
// Depends on bmsh_pkg.
`default_nettype none

module bmsh_merge #(
	parameter int ROWS = 8
) (
	input  wire bmsh_pkg::op_t                 operation,
	input  wire logic [bmsh_pkg::COL_W-1:0]    column,
	input  wire bmsh_pkg::lane_result_t        lanes [ROWS],
	output bmsh_pkg::out_beat_t                beat
);

	bmsh_pkg::lane_result_t merged;

	// OR the lanes together; at most one lane reports a hit
	always_comb begin
		merged = '0;
		for (int l = 0; l < ROWS; l++) begin
			merged = merged | lanes[l];
		end
		beat                = '0;
		beat.fresh_valid    = merged.fresh;
		beat.sample_count   = merged.count;
		beat.history_bits   = merged.history;
		if (operation == bmsh_pkg::OP_SCAN) begin
			beat.column_scanned = column;
		end
	end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for button_matrix_scan_history.
// Runs a directed table, then random scan and read beats.
// Depends on bmsh_pkg and the block's RTL; predicts every result beat and checks it in order.
`default_nettype none

module tb_top;

	localparam int COLS_N     = 8;
	localparam int ROWS_N     = 8;
	localparam int INPUT_N    = 64;
	localparam int SLOT_W     = $clog2(INPUT_N);
	localparam int MAX_CNT    = 16;
	localparam int HIST_N     = 16;
	localparam int CYCLE_CAP  = 200000;
	localparam int HOLD_LEN   = 60;
	localparam int PLAN_LEN   = 22;
	localparam int RAND_SEGS  = 8;
	localparam int SEG_ITEMS  = 100;

	// One row of the directed plan; want is used only when typed is set
	typedef struct {
		bmsh_pkg::op_t                op;
		logic [bmsh_pkg::ROW_W-1:0]   rows;
		logic [bmsh_pkg::IDX_W-1:0]   idx;
		bit                           typed;
		bmsh_pkg::out_beat_t          want;
	} plan_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          operation;
	logic [bmsh_pkg::ROW_W-1:0]    row_levels;
	logic [bmsh_pkg::IDX_W-1:0]    input_index;
	logic                          out_valid;
	logic                          out_stall;
	logic [bmsh_pkg::COL_W-1:0]    column_scanned;
	logic                          fresh_valid;
	logic [bmsh_pkg::CNT_W-1:0]    sample_count;
	logic [bmsh_pkg::HIST_W-1:0]   history_bits;

	// Shadow copy of the matrix state
	logic [HIST_N-1:0]             press_history [INPUT_N];
	logic [bmsh_pkg::CNT_W-1:0]    sample_tally [INPUT_N];
	int                            scan_column;

	bmsh_pkg::out_beat_t           expected_reports [$];
	int                            mismatch_count = 0;
	int                            cycle_count;
	bit                            sender_idle;
	bit                            receiver_idle;
	bit                            hold_req;
	plan_row_t                     plan [PLAN_LEN];

	button_matrix_scan_history #(
		.COLUMNS(COLS_N),
		.ROWS(ROWS_N),
		.INPUTS(INPUT_N),
		.MAX_COUNT(MAX_CNT),
		.HISTORY_WIDTH(HIST_N)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.row_levels(row_levels),
		.input_index(input_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.column_scanned(column_scanned),
		.fresh_valid(fresh_valid),
		.sample_count(sample_count),
		.history_bits(history_bits)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one beat to the shadow state and work out the result it causes
	task automatic update_matrix_and_report(input bmsh_pkg::op_t op,
			input logic [bmsh_pkg::ROW_W-1:0] rows,
			input logic [bmsh_pkg::IDX_W-1:0] idx, output bmsh_pkg::out_beat_t rep);
		int n;
		rep = '0;
		if (op == bmsh_pkg::OP_SCAN) begin
			for (int r = 0; r < ROWS_N; r++) begin
				n = (ROWS_N - 1 - r) * COLS_N + scan_column;
				if (n < INPUT_N) begin
					press_history[n] = {press_history[n][HIST_N-2:0], ~rows[r]};
					if (sample_tally[n] < MAX_CNT)
						sample_tally[n] = sample_tally[n] + 1'b1;
				end
			end
			rep.column_scanned = scan_column[bmsh_pkg::COL_W-1:0];
			scan_column = (scan_column + 1 >= COLS_N) ? 0 : scan_column + 1;
		end else if (idx < INPUT_N) begin
			rep.fresh_valid  = (sample_tally[idx[SLOT_W-1:0]] != 0);
			rep.sample_count = sample_tally[idx[SLOT_W-1:0]];
			rep.history_bits = press_history[idx[SLOT_W-1:0]];
			sample_tally[idx[SLOT_W-1:0]] = '0;
		end
	endtask

	// Offer one beat (after a random gap while sender_idle is set), hold it until taken, then record its result
	task automatic offer_beat(input bmsh_pkg::op_t op, input logic [bmsh_pkg::ROW_W-1:0] rows,
			input logic [bmsh_pkg::IDX_W-1:0] idx, input bit typed,
			input bmsh_pkg::out_beat_t want);
		int gap;
		bmsh_pkg::out_beat_t pred;
		gap = sender_idle ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		operation   <= op;
		row_levels  <= rows;
		input_index <= idx;
		do @(posedge clk); while (in_stall);
		update_matrix_and_report(op, rows, idx, pred);
		expected_reports.push_back(typed ? want : pred);
	endtask

	// Receiver: random stall before each beat while receiver_idle is set, plus one long hold-off on request
	initial begin
		int n;
		bit held;
		out_stall = 1'b0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			n = receiver_idle ? $urandom_range(0, 3) : 0;
			if (hold_req && !held) begin
				n    = HOLD_LEN;
				held = 1'b1;
			end
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Check every accepted result beat against the oldest expectation
	always @(posedge clk) begin
		bmsh_pkg::out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected result beat: column_scanned %0d fresh_valid %0d",
					column_scanned, fresh_valid);
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				if (column_scanned !== want.column_scanned) begin
					$error("column_scanned: expected %0d, got %0d",
						want.column_scanned, column_scanned);
					mismatch_count++;
				end
				if (fresh_valid !== want.fresh_valid) begin
					$error("fresh_valid: expected %0d, got %0d",
						want.fresh_valid, fresh_valid);
					mismatch_count++;
				end
				if (sample_count !== want.sample_count) begin
					$error("sample_count: expected %0d, got %0d",
						want.sample_count, sample_count);
					mismatch_count++;
				end
				if (history_bits !== want.history_bits) begin
					$error("history_bits: expected %h, got %h",
						want.history_bits, history_bits);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run if it never drains
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_CAP) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		bmsh_pkg::op_t              op;
		logic [bmsh_pkg::ROW_W-1:0] rows;
		logic [bmsh_pkg::IDX_W-1:0] idx;
		logic [bmsh_pkg::IDX_W-1:0] last_read;
		int                         pick;
		int                         rnd;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		operation      = bmsh_pkg::OP_SCAN;
		row_levels     = '0;
		input_index    = '0;
		sender_idle    = 1'b1;
		receiver_idle  = 1'b1;
		hold_req       = 1'b0;
		scan_column    = 0;
		last_read      = '0;
		for (int i = 0; i < INPUT_N; i++) begin
			press_history[i] = '0;
			sample_tally[i]  = '0;
		end

		// Directed plan: empty reads, out-of-range reads, a full column sweep with wrap, reads of
		// corner inputs, more out-of-range reads, one scan and one read; junk in each unused field
		plan = '{
			'{bmsh_pkg::OP_READ, 8'h00, 7'd0,   1'b1, '{3'd0, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_READ, 8'hFF, 7'd63,  1'b1, '{3'd0, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_READ, 8'h00, 7'd64,  1'b1, '{3'd0, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_READ, 8'h00, 7'd127, 1'b1, '{3'd0, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_SCAN, 8'h00, 7'd127, 1'b1, '{3'd0, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_SCAN, 8'hFF, 7'd0,   1'b1, '{3'd1, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_SCAN, 8'hA5, 7'd64,  1'b1, '{3'd2, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_SCAN, 8'h5A, 7'd0,   1'b1, '{3'd3, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_SCAN, 8'h0F, 7'd0,   1'b1, '{3'd4, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_SCAN, 8'hF0, 7'd0,   1'b1, '{3'd5, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_SCAN, 8'h01, 7'd0,   1'b1, '{3'd6, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_SCAN, 8'h80, 7'd0,   1'b1, '{3'd7, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_SCAN, 8'h00, 7'd0,   1'b1, '{3'd0, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_READ, 8'hFF, 7'd56,  1'b0, '0},
			'{bmsh_pkg::OP_READ, 8'h00, 7'd56,  1'b0, '0},
			'{bmsh_pkg::OP_READ, 8'h00, 7'd7,   1'b0, '0},
			'{bmsh_pkg::OP_READ, 8'h00, 7'd63,  1'b0, '0},
			'{bmsh_pkg::OP_READ, 8'h00, 7'd0,   1'b0, '0},
			'{bmsh_pkg::OP_READ, 8'h00, 7'd127, 1'b1, '{3'd0, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_READ, 8'h00, 7'd100, 1'b1, '{3'd0, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_SCAN, 8'h7E, 7'd0,   1'b1, '{3'd1, 1'b0, 5'd0, 16'h0}},
			'{bmsh_pkg::OP_READ, 8'h00, 7'd57,  1'b0, '0}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			offer_beat(plan[i].op, plan[i].rows, plan[i].idx, plan[i].typed, plan[i].want);

		// Random part: mostly scans so counts saturate, reads spread over in and out of range
		for (int seg = 0; seg < RAND_SEGS; seg++) begin
			sender_idle   = (seg % 3 != 2);
			receiver_idle = (seg % 4 != 3);
			if (seg == 3)
				hold_req = 1'b1;
			for (int k = 0; k < SEG_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				rnd  = $urandom_range(0, 255);
				rows = rnd[bmsh_pkg::ROW_W-1:0];
				rnd  = $urandom_range(0, 127);
				idx  = rnd[bmsh_pkg::IDX_W-1:0];
				if (pick < 70) begin
					op = bmsh_pkg::OP_SCAN;
				end else begin
					op = bmsh_pkg::OP_READ;
					if (pick < 75) begin
						idx = last_read;
					end else if (pick < 95) begin
						rnd = $urandom_range(0, INPUT_N - 1);
						idx = rnd[bmsh_pkg::IDX_W-1:0];
					end
					last_read = idx;
				end
				offer_beat(op, rows, idx, 1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then keep the clock running to catch any stray beats
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
